@@ src/lsst_pkg.sv @@
// Shared types, constants and helper functions of the lap and sector split timer.
package lsst_pkg;

  // Width of the time accumulators and of the time fields on the ports.
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned NUM_SECTORS = 3;
  localparam int unsigned SECTOR_W    = 2;

  localparam logic [SECTOR_W-1:0] LAST_SECTOR = SECTOR_W'(NUM_SECTORS - 1);
  localparam logic [TIME_W-1:0]   TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = {COUNT_W{1'b1}};

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_ADVANCE  = 2'd0,
    OP_NEXT_LAP = 2'd1,
    OP_CLEAR    = 2'd2
  } lsst_op_e;

  // One input word.
  typedef struct packed {
    logic [1:0]          op;
    logic [DELTA_W-1:0]  delta_time;
    logic                boundary_crossed;
    logic [SECTOR_W-1:0] crossed_sector;
    logic                lap_finished;
  } lsst_item_t;

  // One result word.
  typedef struct packed {
    logic                sector_done;
    logic [SECTOR_W-1:0] sector_index;
    logic [TIME_W-1:0]   sector_time;
    logic                lap_done;
    logic [TIME_W-1:0]   lap_time;
    logic [TIME_W-1:0]   last_lap_time;
    logic [TIME_W-1:0]   best_lap_time;
    logic [TIME_W-1:0]   best_sector_time;
    logic [COUNT_W-1:0]  laps_done;
    logic [SECTOR_W-1:0] sector_now;
    logic [TIME_W-1:0]   total_time;
    logic                lap_held;
  } lsst_result_t;

  // Saturating add of an elapsed time onto an accumulator.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0]  acc,
                                                input logic [DELTA_W-1:0] delta);
    logic [TIME_W:0] sum;
    sum = {1'b0, acc} + {{(TIME_W + 1 - DELTA_W){1'b0}}, delta};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // True when a new time beats a stored best, where zero means no best yet.
  function automatic logic beats_best(input logic [TIME_W-1:0] best,
                                      input logic [TIME_W-1:0] t);
    return (best == '0) || (t < best);
  endfunction

endpackage

@@ src/lsst_in_reg.sv @@
// Input register of the split timer: holds one word until the engine consumes it.
module lsst_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsst_pkg::lsst_item_t item_i,
  input  logic                take_i,
  output logic                vld_o,
  output lsst_pkg::lsst_item_t item_o
);
  import lsst_pkg::*;

  logic       vld_q, vld_d;
  lsst_item_t item_q;
  logic       load;

  // The register is free when empty or when its word moves on this cycle.
  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

@@ src/lsst_engine.sv @@
// Timer state and the single-pass update that turns one word into one result.
module lsst_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  step_i,
  input  lsst_pkg::lsst_item_t  item_i,
  output lsst_pkg::lsst_result_t result_o
);
  import lsst_pkg::*;

  logic                          en_q, en_d;
  logic                          held_q, held_d;
  logic [COUNT_W-1:0]            count_q, count_d;
  logic [SECTOR_W-1:0]           exp_q, exp_d;
  logic [TIME_W-1:0]             sec_q, sec_d;
  logic [TIME_W-1:0]             lap_q, lap_d;
  logic [TIME_W-1:0]             last_q, last_d;
  logic [TIME_W-1:0]             best_lap_q, best_lap_d;
  logic [TIME_W-1:0]             total_q, total_d;
  logic [NUM_SECTORS-1:0][TIME_W-1:0] best_q, best_d;
  logic [NUM_SECTORS-1:0]        done_q, done_d;

  logic                sdone, ldone;
  logic [SECTOR_W-1:0] sidx;
  logic [TIME_W-1:0]   stime;
  logic [TIME_W-1:0]   best_sec;
  logic                commit_first;
  logic                exp_open;

  // Next state and the result word, all from the current state and one word.
  always_comb begin
    en_d       = en_q;
    held_d     = held_q;
    count_d    = count_q;
    exp_d      = exp_q;
    sec_d      = sec_q;
    lap_d      = lap_q;
    last_d     = last_q;
    best_lap_d = best_lap_q;
    total_d    = total_q;
    best_d     = best_q;
    done_d     = done_q;
    sdone      = 1'b0;
    ldone      = 1'b0;
    sidx       = '0;
    stime      = '0;
    exp_open   = 1'b0;

    // Whether the expected sector is still uncommitted.
    for (int i = 0; i < NUM_SECTORS; i++) begin
      if (exp_q == SECTOR_W'(i)) begin
        exp_open = !done_q[i];
      end
    end
    commit_first = en_q && item_i.boundary_crossed &&
                   (item_i.crossed_sector == exp_q) && exp_open;

    if (cfg_we_i) begin
      // A register write also clears the whole attempt.
      en_d       = cfg_wdata_i;
      held_d     = 1'b0;
      count_d    = '0;
      exp_d      = '0;
      sec_d      = '0;
      lap_d      = '0;
      last_d     = '0;
      best_lap_d = '0;
      total_d    = '0;
      best_d     = '0;
      done_d     = '0;
    end else if (step_i) begin
      case (item_i.op)
        OP_ADVANCE: begin
          if (!held_q) begin
            lap_d   = sat_add(lap_q, item_i.delta_time);
            total_d = sat_add(total_q, item_i.delta_time);
            if (en_q) begin
              sec_d = sat_add(sec_q, item_i.delta_time);
            end

            // Commit of the reported sector when it is the expected open one.
            if (commit_first) begin
              sdone = 1'b1;
              sidx  = item_i.crossed_sector;
              stime = sec_d;
              for (int i = 0; i < NUM_SECTORS; i++) begin
                if (item_i.crossed_sector == SECTOR_W'(i)) begin
                  done_d[i] = 1'b1;
                  if (beats_best(best_q[i], sec_d)) begin
                    best_d[i] = sec_d;
                  end
                end
              end
              sec_d = '0;
              if (item_i.crossed_sector != LAST_SECTOR) begin
                exp_d = item_i.crossed_sector + SECTOR_W'(1);
              end
            end

            if (item_i.lap_finished) begin
              // Forced commit of the last sector; it overrides the one above.
              if (en_q && !done_d[NUM_SECTORS-1] && (exp_d == LAST_SECTOR)) begin
                sdone                  = 1'b1;
                sidx                   = LAST_SECTOR;
                stime                  = sec_d;
                done_d[NUM_SECTORS-1]  = 1'b1;
                if (beats_best(best_d[NUM_SECTORS-1], sec_d)) begin
                  best_d[NUM_SECTORS-1] = sec_d;
                end
                sec_d = '0;
              end
              last_d = lap_d;
              if (beats_best(best_lap_q, lap_d)) begin
                best_lap_d = lap_d;
              end
              if (count_q != COUNT_MAX) begin
                count_d = count_q + COUNT_W'(1);
              end
              held_d = 1'b1;
              ldone  = 1'b1;
            end
          end
        end
        OP_NEXT_LAP: begin
          exp_d  = '0;
          sec_d  = '0;
          lap_d  = '0;
          done_d = '0;
          held_d = 1'b0;
        end
        OP_CLEAR: begin
          held_d     = 1'b0;
          count_d    = '0;
          exp_d      = '0;
          sec_d      = '0;
          lap_d      = '0;
          last_d     = '0;
          best_lap_d = '0;
          total_d    = '0;
          best_d     = '0;
          done_d     = '0;
        end
        default: begin
          // The unused code leaves the state alone.
        end
      endcase
    end

    // Best split of the committed sector, zero when nothing was committed.
    best_sec = '0;
    for (int i = 0; i < NUM_SECTORS; i++) begin
      if (sdone && (sidx == SECTOR_W'(i))) begin
        best_sec = best_d[i];
      end
    end
  end

  always_comb begin
    result_o.sector_done      = sdone;
    result_o.sector_index     = sidx;
    result_o.sector_time      = stime;
    result_o.lap_done         = ldone;
    result_o.lap_time         = lap_d;
    result_o.last_lap_time    = last_d;
    result_o.best_lap_time    = best_lap_d;
    result_o.best_sector_time = best_sec;
    result_o.laps_done        = count_d;
    result_o.sector_now       = exp_d;
    result_o.total_time       = total_d;
    result_o.lap_held         = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      held_q     <= 1'b0;
      count_q    <= '0;
      exp_q      <= '0;
      sec_q      <= '0;
      lap_q      <= '0;
      last_q     <= '0;
      best_lap_q <= '0;
      total_q    <= '0;
      best_q     <= '0;
      done_q     <= '0;
    end else begin
      en_q       <= en_d;
      held_q     <= held_d;
      count_q    <= count_d;
      exp_q      <= exp_d;
      sec_q      <= sec_d;
      lap_q      <= lap_d;
      last_q     <= last_d;
      best_lap_q <= best_lap_d;
      total_q    <= total_d;
      best_q     <= best_d;
      done_q     <= done_d;
    end
  end

endmodule

@@ src/lsst_out_reg.sv @@
// Result register of the split timer: holds one result word until it is taken.
module lsst_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  lsst_pkg::lsst_result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lsst_pkg::lsst_result_t result_o
);
  import lsst_pkg::*;

  logic         vld_q, vld_d;
  lsst_result_t res_q;

  // A new word may enter when the register is empty or is read this cycle.
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

@@ src/lap_sector_split_timer_core.sv @@
// Top level of the lap and sector split timer.
//
//   channel  direction  handshake                accepted when
//   input    in         in_valid_i / in_stall_o  in_valid_i && !in_stall_o
//   result   out        out_valid_o / out_stall_i out_valid_o && !out_stall_i
//   config   in         cfg_we_i                 cfg_we_i
//
// Every input word gives exactly one result word: it waits in the input register,
// then passes through the update logic into the result register. A new word is
// taken every cycle while the output is not stalled.
// The state update sits between the input and result registers, so the next
// word always sees the state left by the previous one.
// Reset clears all timer state and the sector-enable register at once.
// An output stall holds the result; one more word can wait in the input register.
module lap_sector_split_timer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [lsst_pkg::DELTA_W-1:0]   delta_time_i,
  input  logic                           boundary_crossed_i,
  input  logic [lsst_pkg::SECTOR_W-1:0]  crossed_sector_i,
  input  logic                           lap_finished_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           sector_done_o,
  output logic [lsst_pkg::SECTOR_W-1:0]  sector_index_o,
  output logic [lsst_pkg::TIME_W-1:0]    sector_time_o,
  output logic                           lap_done_o,
  output logic [lsst_pkg::TIME_W-1:0]    lap_time_o,
  output logic [lsst_pkg::TIME_W-1:0]    last_lap_time_o,
  output logic [lsst_pkg::TIME_W-1:0]    best_lap_time_o,
  output logic [lsst_pkg::TIME_W-1:0]    best_sector_time_o,
  output logic [lsst_pkg::COUNT_W-1:0]   laps_done_o,
  output logic [lsst_pkg::SECTOR_W-1:0]  sector_now_o,
  output logic [lsst_pkg::TIME_W-1:0]    total_time_o,
  output logic                           lap_held_o
);
  import lsst_pkg::*;

  lsst_item_t   item_in, item_q;
  lsst_result_t result_d, result_q;
  logic         item_vld, out_ready, step;

  // Gather the input fields into one word.
  always_comb begin
    item_in.op               = op_i;
    item_in.delta_time       = delta_time_i;
    item_in.boundary_crossed = boundary_crossed_i;
    item_in.crossed_sector   = crossed_sector_i;
    item_in.lap_finished     = lap_finished_i;
  end

  assign step = item_vld && out_ready;

  lsst_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (step),
    .vld_o      (item_vld),
    .item_o     (item_q)
  );

  lsst_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item_q),
    .result_o    (result_d)
  );

  lsst_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result_d),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  // Spread the result word onto the output ports.
  assign sector_done_o      = result_q.sector_done;
  assign sector_index_o     = result_q.sector_index;
  assign sector_time_o      = result_q.sector_time;
  assign lap_done_o         = result_q.lap_done;
  assign lap_time_o         = result_q.lap_time;
  assign last_lap_time_o    = result_q.last_lap_time;
  assign best_lap_time_o    = result_q.best_lap_time;
  assign best_sector_time_o = result_q.best_sector_time;
  assign laps_done_o        = result_q.laps_done;
  assign sector_now_o       = result_q.sector_now;
  assign total_time_o       = result_q.total_time;
  assign lap_held_o         = result_q.lap_held;

endmodule

@@ src/lsst_checker.sv @@
// Port-level checks of the split timer and the bind that attaches them.
module lsst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          sector_done_o,
  input logic [lsst_pkg::SECTOR_W-1:0] sector_index_o,
  input logic [lsst_pkg::TIME_W-1:0]   sector_time_o,
  input logic [lsst_pkg::TIME_W-1:0]   best_sector_time_o,
  input logic                          lap_done_o,
  input logic                          lap_held_o,
  input logic [lsst_pkg::SECTOR_W-1:0] sector_now_o
);
  import lsst_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A completed lap always leaves the timer frozen.
  a_lap_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lap_done_o |-> lap_held_o)
    else $error("lap completed without freezing");

  // Without a commit the sector fields read as zero.
  a_no_commit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sector_done_o |->
      (sector_index_o == '0) && (sector_time_o == '0) && (best_sector_time_o == '0))
    else $error("sector fields set without a commit");

  // Sector indexes stay within the three sectors.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_index_o != 2'd3) && (sector_now_o != 2'd3))
    else $error("sector index out of range");

endmodule

bind lap_sector_split_timer_core lsst_checker u_lsst_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .sector_done_o      (sector_done_o),
  .sector_index_o     (sector_index_o),
  .sector_time_o      (sector_time_o),
  .best_sector_time_o (best_sector_time_o),
  .lap_done_o         (lap_done_o),
  .lap_held_o         (lap_held_o),
  .sector_now_o       (sector_now_o)
);
